// ===== design/btd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btd_pkg : shared types and constants for the prefix-code trie decoder
// Item and result codes, the queue entry and parameter defaults.
// ----------------------------------------------------------------------------
package btd_pkg;

  localparam int NODE_SLOTS_DEF  = 512;
  localparam int SYMBOL_BITS_DEF = 8;

  // fixed field widths of the channels
  localparam int MODE_W = 2;
  localparam int SYM_W  = 8;
  localparam int STAT_W = 2;

  // mode field codes
  localparam logic [MODE_W-1:0] MODE_DECODE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    OP_DECODE,
    OP_LOAD,
    OP_CLEAR,
    OP_IGNORE
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_SYMBOL  = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic             bit_value;
    logic [SYM_W-1:0] symbol;
    logic             code_end;
  } item_t;

endpackage

// ===== design/btd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btd_in_if : input item channel
// Valid/ready channel carrying one decode, load or clear item per beat.
// ----------------------------------------------------------------------------
interface btd_in_if;
  logic                        valid;
  logic                        ready;
  logic [btd_pkg::MODE_W-1:0] mode;
  logic                        bit_value;
  logic [btd_pkg::SYM_W-1:0]  symbol;
  logic                        code_end;

  modport source (output valid, output mode, output bit_value, output symbol,
                  output code_end, input ready);
  modport sink   (input valid, input mode, input bit_value, input symbol,
                  input code_end, output ready);
endinterface

// ===== design/btd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btd_out_if : result channel
// Valid/ready channel carrying one decoded symbol and its status per beat.
// ----------------------------------------------------------------------------
interface btd_out_if;
  logic                        valid;
  logic                        ready;
  logic [btd_pkg::SYM_W-1:0]  decoded_symbol;
  logic [btd_pkg::STAT_W-1:0] status;

  modport source (output valid, output decoded_symbol, output status, input ready);
  modport sink   (input valid, input decoded_symbol, input status, output ready);
endinterface

// ===== design/btd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btd_front : item intake and classification
// Accepts input beats, turns the mode field into an operation code and holds
// the items in a two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module btd_front (
  input  logic           clk,
  input  logic           rst_n,
  btd_in_if.sink         in_ch,
  output logic           q_vld,
  output btd_pkg::item_t q_item,
  input  logic           q_pop
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  btd_pkg::item_t ent_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           push;
  btd_pkg::item_t cls;

  assign in_ch.ready = (cnt_r != CW'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_vld       = (cnt_r != '0);
  assign q_item      = ent_r[rd_ptr_r];

  always_comb begin
    cls.bit_value = in_ch.bit_value;
    cls.symbol    = in_ch.symbol;
    cls.code_end  = in_ch.code_end;
    case (in_ch.mode)
      btd_pkg::MODE_DECODE: cls.op = btd_pkg::OP_DECODE;
      btd_pkg::MODE_LOAD:   cls.op = btd_pkg::OP_LOAD;
      btd_pkg::MODE_CLEAR:  cls.op = btd_pkg::OP_CLEAR;
      default:              cls.op = btd_pkg::OP_IGNORE;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push  ? PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    case ({push, q_pop})
      2'b10:   cnt_nxt = CW'(cnt_r + 1'b1);
      2'b01:   cnt_nxt = CW'(cnt_r - 1'b1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== design/btd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btd_back : trie walk and node store
// Node store, cursors and allocation; one record read per item, the next
// read address taken from the current record. Registered result stage.
// ----------------------------------------------------------------------------
module btd_back #(
  parameter int NODE_SLOTS  = btd_pkg::NODE_SLOTS_DEF,
  parameter int SYMBOL_BITS = btd_pkg::SYMBOL_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_vld,
  input  btd_pkg::item_t q_item,
  output logic           q_pop,
  btd_out_if.source      out_ch
);

  localparam int AW = $clog2(NODE_SLOTS);
  localparam int CW = $clog2(NODE_SLOTS + 1);
  localparam int LW = SYMBOL_BITS + 1;         // labelled flag on top
  localparam int HW = AW + LW;                 // one side: {child, child label}
  localparam int RW = 2 * HW;                  // {right side, left side}
  localparam int XW = SYMBOL_BITS + btd_pkg::SYM_W;

  // record of node n holds both child pointers and the labels of those children
  logic [RW-1:0] mem [NODE_SLOTS];
  logic [RW-1:0] rdata_r;

  logic           byp_vld_r;
  logic [AW-1:0]  byp_addr_r;
  logic [RW-1:0]  byp_data_r;
  logic           root_ok_r, root_ok_nxt;

  logic           x_vld_r, x_vld_nxt;
  logic           x_ph2_r, x_ph2_nxt;
  btd_pkg::item_t x_item_r;
  logic [AW-1:0]  x_addr_r;
  logic [AW-1:0]  x_new_r;

  logic [CW-1:0]  nodes_used_r, nodes_used_nxt;
  logic [AW-1:0]  dec_cur_r, dec_cur_nxt;
  logic [AW-1:0]  bld_cur_r, bld_cur_nxt;

  logic                       out_vld_r, out_vld_nxt;
  logic [btd_pkg::SYM_W-1:0]  out_sym_r;
  btd_pkg::status_t           out_stat_r;

  logic [RW-1:0]  rec;
  logic [HW-1:0]  half, new_half;
  logic [AW-1:0]  ptr;
  logic [LW-1:0]  lab, lab_new;
  logic [XW-1:0]  sym_ext, lab_out_ext;
  logic [AW-1:0]  dec_calc, bld_calc;
  logic           emit, alloc, pwe, clr, stall, x_go;
  logic [btd_pkg::SYM_W-1:0] emit_sym;
  btd_pkg::status_t          emit_stat;
  logic           we;
  logic [AW-1:0]  wa, rd_addr;
  logic [RW-1:0]  wd;

  always_comb begin
    if (x_addr_r == '0 && !root_ok_r) begin
      rec = '0;
    end else if (byp_vld_r && byp_addr_r == x_addr_r) begin
      rec = byp_data_r;
    end else begin
      rec = rdata_r;
    end
    half        = x_item_r.bit_value ? rec[RW-1:HW] : rec[HW-1:0];
    ptr         = half[HW-1:LW];
    lab         = half[LW-1:0];
    sym_ext     = {{SYMBOL_BITS{1'b0}}, x_item_r.symbol};
    lab_new     = {1'b1, sym_ext[SYMBOL_BITS-1:0]};
    lab_out_ext = {{btd_pkg::SYM_W{1'b0}}, lab[SYMBOL_BITS-1:0]};

    emit      = 1'b0;
    emit_sym  = '0;
    emit_stat = btd_pkg::ST_SYMBOL;
    alloc     = 1'b0;
    pwe       = 1'b0;
    clr       = 1'b0;
    new_half  = half;
    dec_calc  = dec_cur_r;
    bld_calc  = bld_cur_r;

    if (x_vld_r && !x_ph2_r) begin
      case (x_item_r.op)
        btd_pkg::OP_DECODE: begin
          if (ptr == '0) begin
            emit      = 1'b1;
            emit_stat = btd_pkg::ST_MISSING;
            dec_calc  = '0;
          end else if (lab[SYMBOL_BITS]) begin
            emit     = 1'b1;
            emit_sym = lab_out_ext[btd_pkg::SYM_W-1:0];
            dec_calc = '0;
          end else begin
            dec_calc = ptr;
          end
        end
        btd_pkg::OP_LOAD: begin
          if (ptr == '0) begin
            if (nodes_used_r == CW'(NODE_SLOTS)) begin
              emit      = 1'b1;
              emit_stat = btd_pkg::ST_FULL;
              bld_calc  = '0;
            end else begin
              alloc    = 1'b1;
              pwe      = 1'b1;
              new_half = {nodes_used_r[AW-1:0], x_item_r.code_end ? lab_new : LW'(0)};
              bld_calc = x_item_r.code_end ? AW'(0) : nodes_used_r[AW-1:0];
            end
          end else if (x_item_r.code_end) begin
            pwe      = 1'b1;
            new_half = {ptr, lab_new};
            bld_calc = '0;
          end else begin
            bld_calc = ptr;
          end
        end
        btd_pkg::OP_CLEAR: begin
          clr      = 1'b1;
          dec_calc = '0;
          bld_calc = '0;
        end
        default: begin
        end
      endcase
    end

    // a finished result waits only when the output register is still full
    stall = emit && out_vld_r && !out_ch.ready;
    x_go  = x_vld_r && !x_ph2_r && !stall;

    dec_cur_nxt = x_go ? dec_calc : dec_cur_r;
    bld_cur_nxt = x_go ? bld_calc : bld_cur_r;

    if (x_go && alloc) begin
      nodes_used_nxt = CW'(nodes_used_r + 1'b1);
    end else if (x_go && clr) begin
      nodes_used_nxt = CW'(1);
    end else begin
      nodes_used_nxt = nodes_used_r;
    end

    // second phase of an allocation empties the new node's record
    if (x_vld_r && x_ph2_r) begin
      we = 1'b1;
      wa = x_new_r;
      wd = '0;
    end else begin
      we = x_go && pwe;
      wa = x_addr_r;
      wd = x_item_r.bit_value ? {new_half, rec[HW-1:0]} : {rec[RW-1:HW], new_half};
    end

    if (x_go && clr) begin
      root_ok_nxt = 1'b0;
    end else if (we && wa == '0) begin
      root_ok_nxt = 1'b1;
    end else begin
      root_ok_nxt = root_ok_r;
    end

    q_pop   = q_vld && (!x_vld_r || x_ph2_r || (x_go && !alloc));
    rd_addr = (q_item.op == btd_pkg::OP_LOAD) ? bld_cur_nxt : dec_cur_nxt;

    if (q_pop) begin
      x_vld_nxt = 1'b1;
      x_ph2_nxt = 1'b0;
    end else if (x_go && alloc) begin
      x_vld_nxt = 1'b1;
      x_ph2_nxt = 1'b1;
    end else if (x_ph2_r || x_go) begin
      x_vld_nxt = 1'b0;
      x_ph2_nxt = 1'b0;
    end else begin
      x_vld_nxt = x_vld_r;
      x_ph2_nxt = x_ph2_r;
    end

    if (x_go && emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.decoded_symbol = out_sym_r;
  assign out_ch.status         = out_stat_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (q_pop) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_item_r <= q_item;
      x_addr_r <= rd_addr;
    end
    if (x_go && alloc) begin
      x_new_r <= nodes_used_r[AW-1:0];
    end
    if (we) begin
      byp_addr_r <= wa;
      byp_data_r <= wd;
    end
    if (x_go && emit) begin
      out_sym_r  <= emit_sym;
      out_stat_r <= emit_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_vld_r    <= 1'b0;
      root_ok_r    <= 1'b0;
      x_vld_r      <= 1'b0;
      x_ph2_r      <= 1'b0;
      nodes_used_r <= CW'(1);
      dec_cur_r    <= '0;
      bld_cur_r    <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      byp_vld_r    <= byp_vld_r || we;
      root_ok_r    <= root_ok_nxt;
      x_vld_r      <= x_vld_nxt;
      x_ph2_r      <= x_ph2_nxt;
      nodes_used_r <= nodes_used_nxt;
      dec_cur_r    <= dec_cur_nxt;
      bld_cur_r    <= bld_cur_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  a_write_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> x_vld_r)
    else $error("node store written with no item in execution");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nodes_used_r >= CW'(1)) && (nodes_used_r <= CW'(NODE_SLOTS)))
    else $error("node fill count out of range");

  a_init_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    x_ph2_r |=> !x_ph2_r)
    else $error("node initialisation lasted more than one cycle");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |-> !(x_go && emit))
    else $error("waiting result overwritten");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (int'(rd_addr) < NODE_SLOTS))
    else $error("node read beyond the store");

endmodule

// ===== design/binary_trie_prefix_code_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_prefix_code_decoder : prefix-code decoder on a binary trie
// Loads a code table bit by bit into a node store and decodes a compressed
// bit stream by walking that trie, one bit per item.
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless a waiting result stalls; a load that adds
// a node holds the back end in an extra phase that empties the new node; the rate
// is set by the node store read: each record read gives the next address
// reset: synchronous, active low; clears queue, cursors, fill count and result stage
// the node store itself is not swept: the root reads as empty until written
// and every new node is emptied when it is allocated, so no clearing pass
module binary_trie_prefix_code_decoder #(
  parameter int NODE_SLOTS  = btd_pkg::NODE_SLOTS_DEF,
  parameter int SYMBOL_BITS = btd_pkg::SYMBOL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  btd_in_if.sink    in_ch,
  btd_out_if.source out_ch
);

  // queue between intake and execution
  logic           q_vld;
  logic           q_pop;
  btd_pkg::item_t q_item;

  // intake: takes a beat whenever the queue has room, maps mode to an op code
  btd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_vld  (q_vld),
    .q_item (q_item),
    .q_pop  (q_pop)
  );

  // execution: one record per node holds both children and their labels,
  // so a decode bit needs exactly one read; the record of the node just
  // left in execution is bypassed when it was written in the same cycle
  btd_back #(
    .NODE_SLOTS  (NODE_SLOTS),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_vld  (q_vld),
    .q_item (q_item),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== bench/binary_trie_prefix_code_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_prefix_code_decoder_tb : self-checking bench for the trie decoder
// Drives a short scripted opening and then random code tables, decode streams
// and a store-filling pass into the decoder. A local trie model predicts each
// result, and the result channel is checked beat by beat against it. Both
// sides of the link idle at random in rotating phases.
// ----------------------------------------------------------------------------
module binary_trie_prefix_code_decoder_tb;
  import btd_pkg::*;

  localparam int SLOTS       = NODE_SLOTS_DEF;
  localparam int PHASE_BEATS = 75;     // beats per idling phase
  localparam int DRAIN_LIMIT = 4000;   // cycles allowed for the last results
  localparam int ROUND_BEATS = 100;    // random tables until this many beats are sent

  // one row of the scripted opening; typed rows carry their own result
  typedef struct packed {
    op_t             op;
    logic            bit_value;
    logic [SYM_W-1:0] symbol;
    logic            code_end;
    logic            typed;
    logic [SYM_W-1:0] exp_sym;
    status_t         exp_status;
  } script_row_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    status_t         st;
  } result_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_phase_t;

  localparam int SCRIPT_LEN = 23;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // empty root: both branches missing
    '{OP_DECODE, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00, ST_MISSING},
    '{OP_DECODE, 1'b1, 8'hff, 1'b1, 1'b1, 8'h00, ST_MISSING},
    // unused mode code, all ones elsewhere
    '{OP_IGNORE, 1'b1, 8'hff, 1'b1, 1'b0, 8'h00, ST_SYMBOL},
    // table: "0" -> ff, "11" -> 00
    '{OP_LOAD,   1'b0, 8'hff, 1'b1, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_LOAD,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_LOAD,   1'b1, 8'h00, 1'b1, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_DECODE, 1'b0, 8'h00, 1'b0, 1'b1, 8'hff, ST_SYMBOL},
    '{OP_DECODE, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_DECODE, 1'b1, 8'hff, 1'b1, 1'b1, 8'h00, ST_SYMBOL},
    // "10" was never loaded
    '{OP_DECODE, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_DECODE, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00, ST_MISSING},
    // label an inner node, then relabel a leaf
    '{OP_LOAD,   1'b1, 8'ha5, 1'b1, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_DECODE, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_LOAD,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_LOAD,   1'b1, 8'h3c, 1'b1, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_DECODE, 1'b1, 8'h55, 1'b1, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_DECODE, 1'b0, 8'haa, 1'b0, 1'b0, 8'h00, ST_SYMBOL},
    // clear, then a fresh one-entry table
    '{OP_CLEAR,  1'b1, 8'h5a, 1'b1, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_DECODE, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00, ST_MISSING},
    '{OP_LOAD,   1'b0, 8'h5a, 1'b1, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_DECODE, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_IGNORE, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, ST_SYMBOL},
    '{OP_DECODE, 1'b1, 8'h00, 1'b0, 1'b1, 8'h00, ST_MISSING}
  };

  logic clk = 1'b0;
  logic rst_n;

  btd_in_if  in_ch ();
  btd_out_if out_ch ();

  binary_trie_prefix_code_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the node store: child links and labels (bit 8 = labelled)
  logic [8:0]  trie_left  [SLOTS];
  logic [8:0]  trie_right [SLOTS];
  logic [8:0]  trie_label [SLOTS];
  int          trie_nodes_used;
  logic [8:0]  build_at;
  logic [8:0]  decode_at;

  result_t     due_results [$];
  logic [63:0] book_val [$];     // codes loaded since the last clear, msb-first
  int          book_len [$];

  idle_phase_t idle_phase = IDLE_NONE;
  int          beats_sent;
  int          results_seen;
  int          mismatches;
  int          n_symbols;
  int          n_missing;
  int          n_full;
  bit          store_filled;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_trie();
    for (int i = 0; i < SLOTS; i++) begin
      trie_left[i]  = '0;
      trie_right[i] = '0;
      trie_label[i] = '0;
    end
    trie_nodes_used = 1;
    build_at        = '0;
    decode_at       = '0;
  endfunction

  // advance the trie model by one item; found says whether a result is due
  function automatic void walk_trie(input item_t it, output bit found, output result_t res);
    logic [8:0] nxt;
    found = 1'b0;
    res   = '{sym: '0, st: ST_SYMBOL};
    case (it.op)
      OP_DECODE: begin
        nxt = it.bit_value ? trie_right[decode_at] : trie_left[decode_at];
        if (nxt == '0) begin
          // no branch: flag it and restart from the root
          decode_at = '0;
          found     = 1'b1;
          res.st    = ST_MISSING;
        end else if (trie_label[nxt][8]) begin
          // first labelled node wins, even if it has children
          decode_at = '0;
          found     = 1'b1;
          res.sym   = trie_label[nxt][7:0];
        end else begin
          decode_at = nxt;
        end
      end
      OP_LOAD: begin
        nxt = it.bit_value ? trie_right[build_at] : trie_left[build_at];
        if (nxt == '0 && trie_nodes_used >= SLOTS) begin
          // store full: nothing made, nothing labelled, back to the root
          build_at = '0;
          found    = 1'b1;
          res.st   = ST_FULL;
        end else begin
          if (nxt == '0) begin
            nxt = 9'(trie_nodes_used);
            trie_nodes_used++;
            trie_left[nxt]  = '0;
            trie_right[nxt] = '0;
            trie_label[nxt] = '0;
            if (it.bit_value) begin
              trie_right[build_at] = nxt;
            end else begin
              trie_left[build_at] = nxt;
            end
          end
          if (it.code_end) begin
            trie_label[nxt] = {1'b1, it.symbol};
            build_at        = '0;
          end else begin
            build_at = nxt;
          end
        end
      end
      OP_CLEAR: clear_trie();
      default: ;
    endcase
  endfunction

  // present one item on the input link and book its result once accepted
  task automatic send_beat(input item_t it, input bit typed, input result_t typed_res);
    bit      found;
    result_t res;
    @(negedge clk);
    while ((idle_phase == IDLE_SENDER && $urandom_range(99) < 79) ||
           (idle_phase == IDLE_BOTH && $urandom_range(99) < 32)) begin
      // idle cycle: junk on the payload, valid low
      in_ch.valid     <= 1'b0;
      in_ch.mode      <= 2'($urandom);
      in_ch.bit_value <= 1'($urandom);
      in_ch.symbol    <= 8'($urandom);
      in_ch.code_end  <= 1'($urandom);
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= it.op;
    in_ch.bit_value <= it.bit_value;
    in_ch.symbol    <= it.symbol;
    in_ch.code_end  <= it.code_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);

    // the model always steps; a typed row overrides what it predicts
    walk_trie(it, found, res);
    if (typed) begin
      found = 1'b1;
      res   = typed_res;
    end
    if (found) begin
      due_results.push_back(res);
      case (res.st)
        ST_SYMBOL:  n_symbols++;
        ST_MISSING: n_missing++;
        default:    n_full++;
      endcase
    end
    beats_sent++;
    idle_phase = idle_phase_t'((beats_sent / PHASE_BEATS) % 4);
  endtask

  task automatic send_op(input op_t op, input logic b, input logic [7:0] s, input logic e);
    item_t it;
    it = '{op: op, bit_value: b, symbol: s, code_end: e};
    send_beat(it, 1'b0, '0);
  endtask

  task automatic load_code(input logic [63:0] v, input int len, input logic [7:0] s);
    for (int k = len - 1; k >= 0; k--) begin
      send_op(OP_LOAD, v[k], s, k == 0);
    end
  endtask

  // decode items carry random symbol and end fields, which must be ignored
  task automatic decode_code(input logic [63:0] v, input int len);
    for (int k = len - 1; k >= 0; k--) begin
      send_op(OP_DECODE, v[k], 8'($urandom), 1'($urandom));
    end
  endtask

  // one random table: build a prefix-free code, load most of it, then decode with stray items mixed in
  task automatic code_round();
    logic [63:0] leaf_val [$];
    int          leaf_len [$];
    int          n_leaves;
    int          k;
    int          roll;
    logic [63:0] v;
    int          l;
    // most rounds start clean, the rest stack a new table on the old one
    if ($urandom_range(3) != 0) begin
      send_op(OP_CLEAR, 1'($urandom), 8'($urandom), 1'($urandom));
      book_val.delete();
      book_len.delete();
    end
    n_leaves = $urandom_range(2, 24);
    leaf_val.push_back('0);
    leaf_len.push_back(0);
    while (leaf_val.size() < n_leaves) begin
      k = $urandom_range(leaf_val.size() - 1);
      if (leaf_len[k] < 10) begin
        v = leaf_val[k];
        l = leaf_len[k];
        leaf_val[k] = v << 1;
        leaf_len[k] = l + 1;
        leaf_val.push_back((v << 1) | 64'd1);
        leaf_len.push_back(l + 1);
      end
    end
    // leave some codes out so that streams can run into missing branches
    foreach (leaf_val[i]) begin
      if ($urandom_range(99) >= 15) begin
        load_code(leaf_val[i], leaf_len[i], 8'($urandom));
        book_val.push_back(leaf_val[i]);
        book_len.push_back(leaf_len[i]);
      end
    end
    // relabel one code now and then
    if (book_val.size() > 0 && $urandom_range(99) < 30) begin
      k = $urandom_range(book_val.size() - 1);
      load_code(book_val[k], book_len[k], 8'($urandom));
    end
    repeat ($urandom_range(10, 30)) begin
      roll = $urandom_range(99);
      if (roll < 8 || book_val.size() == 0) begin
        send_op(OP_DECODE, 1'($urandom), 8'($urandom), 1'($urandom));
      end else if (roll < 11) begin
        send_op(OP_IGNORE, 1'($urandom), 8'($urandom), 1'($urandom));
      end else if (roll < 13) begin
        send_op(OP_LOAD, 1'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        k = $urandom_range(book_val.size() - 1);
        decode_code(book_val[k], book_len[k]);
      end
    end
  endtask

  // long random codes until the node store runs out, a few more past that
  task automatic fill_store();
    int          past_full;
    logic [63:0] v;
    int          len;
    int          k;
    send_op(OP_CLEAR, 1'($urandom), 8'($urandom), 1'($urandom));
    book_val.delete();
    book_len.delete();
    past_full = 0;
    while (past_full < 3) begin
      if (trie_nodes_used >= SLOTS) past_full++;
      v   = {$urandom, $urandom};
      len = $urandom_range(16, 28);
      load_code(v, len, 8'($urandom));
      book_val.push_back(v);
      book_len.push_back(len);
    end
    store_filled = 1'b1;
    // walk a few deep codes, including ones cut short by the full store
    repeat (6) begin
      k = $urandom_range(book_val.size() - 1);
      decode_code(book_val[k], book_len[k]);
    end
  endtask

  // receiver: ready changes on the falling edge
  always @(negedge clk) begin
    out_ch.ready <= !((idle_phase == IDLE_RECEIVER && $urandom_range(99) < 79) ||
                      (idle_phase == IDLE_BOTH && $urandom_range(99) < 32));
  end

  // result checker: each beat against the oldest result due
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result beat with none due: expected none, got symbol %02h status %0d",
                 $time, out_ch.decoded_symbol, out_ch.status);
      end else begin
        want = due_results.pop_front();
        if (out_ch.decoded_symbol !== want.sym) begin
          mismatches++;
          $display("%0t ns: decoded_symbol mismatch: expected %02h, got %02h",
                   $time, want.sym, out_ch.decoded_symbol);
        end
        if (out_ch.status !== want.st) begin
          mismatches++;
          $display("%0t ns: status mismatch: expected %0d, got %0d",
                   $time, want.st, out_ch.status);
        end
      end
    end
  end

  // main sequence
  initial begin
    item_t   it;
    result_t typed_res;
    int      waited;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_DECODE;
    in_ch.bit_value = 1'b0;
    in_ch.symbol    = '0;
    in_ch.code_end  = 1'b0;
    rst_n           = 1'b0;
    beats_sent      = 0;
    results_seen    = 0;
    mismatches      = 0;
    n_symbols       = 0;
    n_missing       = 0;
    n_full          = 0;
    store_filled    = 1'b0;
    clear_trie();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // scripted opening
    foreach (SCRIPT[i]) begin
      it        = '{op: SCRIPT[i].op, bit_value: SCRIPT[i].bit_value,
                    symbol: SCRIPT[i].symbol, code_end: SCRIPT[i].code_end};
      typed_res = '{sym: SCRIPT[i].exp_sym, st: SCRIPT[i].exp_status};
      send_beat(it, SCRIPT[i].typed, typed_res);
    end

    // random tables, one pass that fills the store, then one more table
    while (beats_sent < ROUND_BEATS) code_round();
    fill_store();
    code_round();

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain: wait for every result due, then watch for strays
    waited = 0;
    while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (due_results.size() != 0) begin
      mismatches++;
      $display("%0t ns: %0d results still due at the end of the run",
               $time, due_results.size());
    end

    $display("ran %0d input beats, checked %0d result beats", beats_sent, results_seen);
    $display("symbols %0d, missing branches %0d, store-full flags %0d, store filled: %0d",
             n_symbols, n_missing, n_full, store_filled);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("%0t ns: run did not complete in time", $time);
    $display("FAILURE");
    $finish;
  end

endmodule
